// ===== rtl/bvfg_pkg.sv =====
// ----------------------------------------------------------------------------
// bvfg_pkg: shared types and constants for the battery voltage fuel gauge
// Beat structs, register indexes, discharge curve and reset values.
// ----------------------------------------------------------------------------
package bvfg_pkg;

    localparam int SAMPLES_PER_READING = 16;
    localparam int ADC_BITS            = 12;
    localparam int IDX_BITS            = $clog2(SAMPLES_PER_READING + 1);
    localparam int SUM_BITS            = ADC_BITS + $clog2(SAMPLES_PER_READING + 1);
    localparam int SMOOTH_BITS         = 22;
    localparam int CURVE_N             = 10;

    localparam logic [SMOOTH_BITS-1:0] SMOOTH_MAX   = {SMOOTH_BITS{1'b1}};
    localparam logic [SMOOTH_BITS-1:0] SMOOTH_RESET = SMOOTH_BITS'(3700 * 256);

    localparam logic [2:0] REG_MV_GAIN      = 3'd0;
    localparam logic [2:0] REG_FULL_MV      = 3'd1;
    localparam logic [2:0] REG_EMPTY_MV     = 3'd2;
    localparam logic [2:0] REG_LOW_PCT      = 3'd3;
    localparam logic [2:0] REG_CRITICAL_PCT = 3'd4;
    localparam logic [2:0] REG_MAX_CYCLES   = 3'd5;
    localparam logic [2:0] REG_START_CYCLES = 3'd6;

    typedef struct packed {
        logic [ADC_BITS-1:0] adc_sample;
        logic                charge_pin;
    } in_beat_t;

    typedef struct packed {
        logic [13:0] voltage_mv;
        logic [6:0]  percent;
        logic        charging;
        logic        low_flag;
        logic        critical_flag;
        logic        replace_flag;
        logic        shutdown_request;
        logic [15:0] cycle_count;
    } out_beat_t;

    // completed reading passed from front to back
    typedef struct packed {
        logic [SUM_BITS-1:0] sum;
        logic                charging;
    } reading_t;

    function automatic logic [12:0] curve_mv(input logic [3:0] i);
        case (i)
            4'd0:    curve_mv = 13'd4200;
            4'd1:    curve_mv = 13'd4100;
            4'd2:    curve_mv = 13'd4000;
            4'd3:    curve_mv = 13'd3920;
            4'd4:    curve_mv = 13'd3800;
            4'd5:    curve_mv = 13'd3700;
            4'd6:    curve_mv = 13'd3600;
            4'd7:    curve_mv = 13'd3500;
            4'd8:    curve_mv = 13'd3350;
            default: curve_mv = 13'd3000;
        endcase
    endfunction

    function automatic logic [6:0] curve_pct(input logic [3:0] i);
        case (i)
            4'd0:    curve_pct = 7'd100;
            4'd1:    curve_pct = 7'd98;
            4'd2:    curve_pct = 7'd95;
            4'd3:    curve_pct = 7'd90;
            4'd4:    curve_pct = 7'd80;
            4'd5:    curve_pct = 7'd65;
            4'd6:    curve_pct = 7'd50;
            4'd7:    curve_pct = 7'd30;
            4'd8:    curve_pct = 7'd15;
            default: curve_pct = 7'd0;
        endcase
    endfunction

endpackage

// ===== rtl/bvfg_front.sv =====
// ----------------------------------------------------------------------------
// bvfg_front: sample accumulator
// Sums samples and emits one reading per SAMPLES_PER_READING beats.
// ----------------------------------------------------------------------------
module bvfg_front import bvfg_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_beat_t s_data,
    output logic     rd_valid,
    input  logic     rd_ready,
    output reading_t rd_data
);

    logic [SUM_BITS-1:0] sum_reg, sum_next;
    logic [IDX_BITS-1:0] idx_reg, idx_next;
    logic                acc;
    logic [SUM_BITS-1:0] new_sum;
    logic                done;

    assign s_ready = rd_ready;
    assign acc     = s_valid && s_ready;
    assign new_sum = sum_reg + SUM_BITS'(s_data.adc_sample);
    assign done    = (idx_reg == IDX_BITS'(SAMPLES_PER_READING - 1));

    assign rd_valid         = acc && done;
    assign rd_data.sum      = new_sum;
    assign rd_data.charging = ~s_data.charge_pin;

    always_comb begin
        sum_next = sum_reg;
        idx_next = idx_reg;
        if (acc) begin
            if (done) begin
                sum_next = '0;
                idx_next = '0;
            end else begin
                sum_next = new_sum;
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            idx_reg <= '0;
        end else begin
            sum_reg <= sum_next;
            idx_reg <= idx_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg < IDX_BITS'(SAMPLES_PER_READING))
        else $error("sample index out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid |=> (idx_reg == '0 && sum_reg == '0))
        else $error("accumulator not cleared after reading");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !acc |=> $stable(idx_reg))
        else $error("index moved without a beat");

endmodule

// ===== rtl/bvfg_queue.sv =====
// ----------------------------------------------------------------------------
// bvfg_queue: two-entry reading queue
// Decouples the accumulator from the filter and curve engine.
// ----------------------------------------------------------------------------
module bvfg_queue import bvfg_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     wr_valid,
    output logic     wr_ready,
    input  reading_t wr_data,
    output logic     rd_valid,
    input  logic     rd_ready,
    output reading_t rd_data
);

    reading_t   mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (wr) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> (wp_reg == rp_reg))
        else $error("queue pointers inconsistent");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd1 |-> (wp_reg != rp_reg))
        else $error("queue pointers inconsistent");

endmodule

// ===== rtl/bvfg_back.sv =====
// ----------------------------------------------------------------------------
// bvfg_back: scale, IIR filter, curve lookup and flags
// Sequencer: multiply, filter, divide by 20 (reciprocal), segment search,
// interpolation, divide by segment span (restoring), then output.
// ----------------------------------------------------------------------------
module bvfg_back import bvfg_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  reading_t    q_data,
    input  logic [15:0] mv_gain,
    input  logic [13:0] full_mv,
    input  logic [13:0] empty_mv,
    input  logic [6:0]  low_pct,
    input  logic [6:0]  critical_pct,
    input  logic [15:0] max_cycles,
    input  logic        cyc_load,
    input  logic [15:0] cyc_value,
    output logic        m_valid,
    input  logic        m_ready,
    output out_beat_t   m_data
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MUL   = 8'b0000_0010,
        ST_FILT  = 8'b0000_0100,
        ST_DIV20 = 8'b0000_1000,
        ST_SEG   = 8'b0001_0000,
        ST_IMUL  = 8'b0010_0000,
        ST_IDIV  = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    state_t                 st_reg;
    logic [SUM_BITS-1:0]    sum_reg;
    logic                   chg_reg;
    logic                   was_chg_reg;
    logic [15:0]            cyc_reg;
    logic [SMOOTH_BITS-1:0] smooth_reg;
    logic [SMOOTH_BITS-1:0] r_reg;
    logic [27:0]            filt_reg;
    logic [3:0]             seg_reg;
    logic [6:0]             pct_reg;
    logic [4:0]             dbits_reg;
    logic [23:0]            num_reg;
    logic [23:0]            rem_reg;
    logic [6:0]             quo_reg;
    logic                   oval_reg;
    out_beat_t              out_reg;

    logic [SUM_BITS+15:0]   prod;
    logic [SUM_BITS+7:0]    r_full;
    logic [SMOOTH_BITS-1:0] lo_s, hi_s;
    logic [56:0]            q20;
    logic [SMOOTH_BITS-1:0] div20;
    logic [23:0]            span;
    logic [24:0]            trial;
    logic [6:0]             pct_fin;
    logic                   low_f, crit_f;

    assign q_ready = st_reg == ST_IDLE;
    assign m_valid = oval_reg;
    assign m_data  = out_reg;

    assign prod   = sum_reg * mv_gain;
    assign r_full = prod[SUM_BITS+15:8];
    assign lo_s   = {1'b0, curve_mv(seg_reg + 4'd1), 8'd0};
    assign hi_s   = {1'b0, curve_mv(seg_reg), 8'd0};
    // floor(x/20) for x < 2^27: x*0x0CCCCCCD >> 32, exact
    assign q20    = filt_reg * 29'h0CCCCCCD;
    assign div20  = q20[SMOOTH_BITS+31:32];
    assign span   = {3'd0, curve_mv(seg_reg) - curve_mv(seg_reg + 4'd1), 8'd0};
    assign trial  = {rem_reg, num_reg[23]} - {1'b0, span};

    always_comb begin
        if (smooth_reg >= {full_mv, 8'd0}) begin
            pct_fin = 7'd100;
        end else if (smooth_reg <= {empty_mv, 8'd0}) begin
            pct_fin = 7'd0;
        end else begin
            pct_fin = pct_reg;
        end
        low_f  = (pct_fin < low_pct) && !chg_reg;
        crit_f = pct_fin < critical_pct;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            oval_reg    <= 1'b0;
            was_chg_reg <= 1'b0;
            cyc_reg     <= '0;
            smooth_reg  <= SMOOTH_RESET;
        end else begin
            if (m_valid && m_ready && st_reg != ST_OUT) oval_reg <= 1'b0;
            if (cyc_load) begin
                cyc_reg <= cyc_value;
            end else if (st_reg == ST_DIV20 && was_chg_reg && !chg_reg &&
                         cyc_reg != 16'hFFFF) begin
                cyc_reg <= cyc_reg + 16'd1;
            end
            case (st_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        sum_reg <= q_data.sum;
                        chg_reg <= q_data.charging;
                        st_reg  <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_reg  <= (r_full > (SUM_BITS+8)'(SMOOTH_MAX)) ? SMOOTH_MAX
                                                               : SMOOTH_BITS'(r_full);
                    st_reg <= ST_FILT;
                end
                ST_FILT: begin
                    filt_reg <= 28'(smooth_reg) * 28'd19 + 28'(r_reg);
                    st_reg   <= ST_DIV20;
                end
                ST_DIV20: begin
                    smooth_reg  <= div20;
                    was_chg_reg <= chg_reg;
                    seg_reg     <= 4'd0;
                    st_reg      <= ST_SEG;
                end
                ST_SEG: begin
                    if (smooth_reg > {1'b0, curve_mv(4'd0), 8'd0}) begin
                        pct_reg <= 7'd100;
                        st_reg  <= ST_OUT;
                    end else if (smooth_reg >= lo_s && smooth_reg <= hi_s) begin
                        st_reg <= ST_IMUL;
                    end else if (seg_reg == 4'(CURVE_N - 2)) begin
                        pct_reg <= 7'd0;
                        st_reg  <= ST_OUT;
                    end else begin
                        seg_reg <= seg_reg + 4'd1;
                    end
                end
                ST_IMUL: begin
                    num_reg   <= 24'(smooth_reg - lo_s) *
                                 24'(curve_pct(seg_reg) - curve_pct(seg_reg + 4'd1));
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    dbits_reg <= 5'd24;
                    st_reg    <= ST_IDIV;
                end
                ST_IDIV: begin
                    if (trial[24]) begin
                        rem_reg <= {rem_reg[22:0], num_reg[23]};
                        quo_reg <= {quo_reg[5:0], 1'b0};
                    end else begin
                        rem_reg <= trial[23:0];
                        quo_reg <= {quo_reg[5:0], 1'b1};
                    end
                    num_reg   <= {num_reg[22:0], 1'b0};
                    dbits_reg <= dbits_reg - 5'd1;
                    if (dbits_reg == 5'd1) begin
                        pct_reg <= curve_pct(seg_reg + 4'd1) +
                                   (trial[24] ? {quo_reg[5:0], 1'b0}
                                              : {quo_reg[5:0], 1'b1});
                        st_reg  <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!oval_reg || m_ready) begin
                        oval_reg                 <= 1'b1;
                        out_reg.voltage_mv       <= smooth_reg[21:8];
                        out_reg.percent          <= pct_fin;
                        out_reg.charging         <= chg_reg;
                        out_reg.low_flag         <= low_f;
                        out_reg.critical_flag    <= crit_f;
                        out_reg.replace_flag     <= cyc_reg > max_cycles;
                        out_reg.shutdown_request <= crit_f && !chg_reg;
                        out_reg.cycle_count      <= cyc_reg;
                        st_reg                   <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) $onehot(st_reg))
        else $error("state not one-hot");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_OUT && (!oval_reg || m_ready)) |=> oval_reg)
        else $error("result lost");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("held result changed");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.percent <= 7'd100)
        else $error("percent out of range");

endmodule

// ===== rtl/battery_voltage_fuel_gauge.sv =====
// Path: the beat completing a reading passes through the reading queue to the back end,
// which steps through the curve segment search and the 24-step interpolation divider.
// Throughput: one sample per cycle while the queue has room; the back end takes a new
// reading only once idle again, and a result stall holds it in its output state.
// Reset: aresetn synchronous active low; registers to reset values, filter
// at 3700 mV, cycle count 0, no clearing pass.
// ----------------------------------------------------------------------------
// battery_voltage_fuel_gauge: LiPo voltage curve fuel gauge top level
// Accumulator, reading queue, filter and curve engine, config registers.
// ----------------------------------------------------------------------------
module battery_voltage_fuel_gauge import bvfg_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_beat_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_beat_t   m_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic [15:0] mv_gain_reg, max_cycles_reg;
    logic [13:0] full_mv_reg, empty_mv_reg;
    logic [6:0]  low_pct_reg, critical_pct_reg;
    logic        f_valid, f_ready, b_valid, b_ready, cyc_load;
    reading_t    f_data, b_data;

    assign cyc_load = cfg_we && cfg_index == REG_START_CYCLES;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_gain_reg      <= 16'd6602;
            full_mv_reg      <= 14'd4200;
            empty_mv_reg     <= 14'd3000;
            low_pct_reg      <= 7'd20;
            critical_pct_reg <= 7'd5;
            max_cycles_reg   <= 16'd500;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MV_GAIN:      mv_gain_reg      <= cfg_wdata;
                REG_FULL_MV:      full_mv_reg      <= cfg_wdata[13:0];
                REG_EMPTY_MV:     empty_mv_reg     <= cfg_wdata[13:0];
                REG_LOW_PCT:      low_pct_reg      <= cfg_wdata[6:0];
                REG_CRITICAL_PCT: critical_pct_reg <= cfg_wdata[6:0];
                REG_MAX_CYCLES:   max_cycles_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    bvfg_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .rd_valid(f_valid), .rd_ready(f_ready), .rd_data(f_data)
    );

    bvfg_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
    );

    bvfg_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
        .mv_gain(mv_gain_reg), .full_mv(full_mv_reg), .empty_mv(empty_mv_reg),
        .low_pct(low_pct_reg), .critical_pct(critical_pct_reg),
        .max_cycles(max_cycles_reg), .cyc_load(cyc_load), .cyc_value(cfg_wdata),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the battery voltage fuel gauge
// Streams ADC samples with random charger levels across several register
// settings, predicts each reading (filter, curve, flags, cycle count) and
// checks every result beat against it under random idling and back-pressure.
// ----------------------------------------------------------------------------
module testbench;
    import bvfg_pkg::*;

    localparam int          CLK_PERIOD  = 12;
    localparam int          SETTLE      = 80;
    localparam int          LIMIT       = 600000;
    localparam logic [2:0]  REG_UNUSED  = 3'd7;

    class gauge_scoreboard;
        out_beat_t   pending[$];
        int          fails;
        logic [15:0] gain;
        logic [13:0] full_mv;
        logic [13:0] empty_mv;
        logic [6:0]  low_pct;
        logic [6:0]  crit_pct;
        logic [15:0] max_cycles;
        logic [15:0] cycles;
        logic [31:0] sum;
        int          count;
        logic [31:0] smooth;
        bit          was_charging;
        int unsigned knee_mv[10];
        int unsigned knee_pct[10];

        function new();
            knee_mv  = '{4200, 4100, 4000, 3920, 3800, 3700, 3600, 3500, 3350, 3000};
            knee_pct = '{100, 98, 95, 90, 80, 65, 50, 30, 15, 0};
            fails = 0;
            gain = 16'd6602;
            full_mv = 14'd4200;
            empty_mv = 14'd3000;
            low_pct = 7'd20;
            crit_pct = 7'd5;
            max_cycles = 16'd500;
            cycles = '0;
            sum = '0;
            count = 0;
            smooth = 3700 * 256;
            was_charging = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            fails++;
        endtask

        function void write_reg(logic [2:0] idx, logic [15:0] v);
            case (idx)
                REG_MV_GAIN:      gain = v;
                REG_FULL_MV:      full_mv = v[13:0];
                REG_EMPTY_MV:     empty_mv = v[13:0];
                REG_LOW_PCT:      low_pct = v[6:0];
                REG_CRITICAL_PCT: crit_pct = v[6:0];
                REG_MAX_CYCLES:   max_cycles = v;
                REG_START_CYCLES: cycles = v;
                default: ;
            endcase
        endfunction

        function int unsigned percent_of(logic [31:0] s);
            int unsigned hi, lo;
            if (s >= {full_mv, 8'd0}) return 100;
            if (s <= {empty_mv, 8'd0}) return 0;
            if (s > knee_mv[0] * 256) return 100;
            for (int i = 0; i < 9; i++) begin
                hi = knee_mv[i] * 256;
                lo = knee_mv[i + 1] * 256;
                if (s <= hi && s >= lo)
                    return knee_pct[i + 1]
                         + ((s - lo) * (knee_pct[i] - knee_pct[i + 1])) / (hi - lo);
            end
            return 0;
        endfunction

        function void note_sample(in_beat_t b);
            logic [63:0] r;
            int unsigned pct;
            bit          chg, low, crit;
            out_beat_t   e;
            sum += b.adc_sample;
            count++;
            if (count < SAMPLES_PER_READING) return;
            r = (64'(sum) * gain) >> 8;
            if (r > 64'h3FFFFF) r = 64'h3FFFFF;
            sum = '0;
            count = 0;
            smooth = 32'((64'(smooth) * 19 + r) / 20);
            chg = !b.charge_pin;
            if (was_charging && !chg && cycles != 16'hFFFF) cycles++;
            was_charging = chg;
            pct = percent_of(smooth);
            low = (pct < low_pct) && !chg;
            crit = pct < crit_pct;
            e.voltage_mv = smooth[21:8];
            e.percent = pct[6:0];
            e.charging = chg;
            e.low_flag = low;
            e.critical_flag = crit;
            e.replace_flag = cycles > max_cycles;
            e.shutdown_request = crit && !chg;
            e.cycle_count = cycles;
            pending.push_back(e);
        endfunction

        task field(string name, int got, int want);
            if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check(out_beat_t got);
            out_beat_t e;
            if (pending.size() == 0) begin
                report("result beat with no reading pending");
                return;
            end
            e = pending.pop_front();
            field("voltage_mv", got.voltage_mv, e.voltage_mv);
            field("percent", got.percent, e.percent);
            field("charging", got.charging, e.charging);
            field("low_flag", got.low_flag, e.low_flag);
            field("critical_flag", got.critical_flag, e.critical_flag);
            field("replace_flag", got.replace_flag, e.replace_flag);
            field("shutdown_request", got.shutdown_request, e.shutdown_request);
            field("cycle_count", got.cycle_count, e.cycle_count);
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_beat_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_beat_t   m_data;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;

    gauge_scoreboard sb = new();
    int  cycle_no = 0;
    int  burst_left;
    bit  hold_off;
    bit  pressure_go;

    battery_voltage_fuel_gauge dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_sample(s_data);
            if (m_valid && m_ready) sb.check(m_data);
        end
    end

    // receiver stall pattern, with a long hold-off on request
    int stall_mode = 0;
    int stall_left = 0;
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        if (hold_off)
            m_ready <= 1'b0;
        else case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= cycle_no[2];
        endcase
    end

    initial begin
        hold_off = 0;
        wait (pressure_go);
        hold_off = 1;
        repeat (2500) @(posedge aclk);
        hold_off = 0;
    end

    task write_reg(logic [2:0] idx, logic [15:0] v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        sb.write_reg(idx, v);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task drain;
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        wait (sb.pending.size() == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task send_sample(logic [11:0] smp, logic pin);
        if (burst_left == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge aclk);
            burst_left = ($urandom_range(0, 2) == 0) ? 200 : $urandom_range(1, 30);
        end else begin
            @(negedge aclk);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data <= '{adc_sample: smp, charge_pin: pin};
        do @(posedge aclk); while (!s_ready);
    endtask

    // one reading of 16 samples around a level; the pin level of the last beat counts
    task send_reading(int level, int spread, logic pin_last);
        int v;
        for (int i = 0; i < SAMPLES_PER_READING; i++) begin
            v = level + $urandom_range(0, 2 * spread) - spread;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
            if (i == SAMPLES_PER_READING - 1)
                send_sample(12'(v), pin_last);
            else
                send_sample(12'(v), 1'($urandom));
        end
    endtask

    task config_all(logic [15:0] g, logic [13:0] f, logic [13:0] e, logic [6:0] lo,
                    logic [6:0] cr, logic [15:0] mx, logic [15:0] st);
        write_reg(REG_MV_GAIN, g);
        write_reg(REG_FULL_MV, {2'($urandom), f});
        write_reg(REG_EMPTY_MV, {2'($urandom), e});
        write_reg(REG_LOW_PCT, {9'($urandom), lo});
        write_reg(REG_CRITICAL_PCT, {9'($urandom), cr});
        write_reg(REG_MAX_CYCLES, mx);
        write_reg(REG_START_CYCLES, st);
        write_reg(REG_UNUSED, 16'($urandom));
    endtask

    int level;
    initial begin
        burst_left = 0;
        pressure_go = 0;
        aresetn = 0;
        s_valid = 0;
        s_data = '0;
        m_ready = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // defaults, extremes of the sample, charging edges
        send_reading(4095, 0, 1'b0);
        send_reading(0, 0, 1'b1);
        send_reading(2300, 40, 1'b0);
        send_reading(2300, 40, 1'b1);
        drain();

        // saturating cycle count, zero gain, widest thresholds
        config_all(16'd0, 14'd16383, 14'd0, 7'd100, 7'd100, 16'd0, 16'hFFFE);
        for (int i = 0; i < 6; i++) send_reading(4095, 0, 1'(i));
        drain();

        // full gain saturates the reading; thresholds zero
        config_all(16'hFFFF, 14'd0, 14'd16383, 7'd0, 7'd0, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 4; i++) send_reading(4095, 0, 1'(i));
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            config_all(16'($urandom_range(5000, 9000)),
                       14'($urandom_range(3400, 4400)), 14'($urandom_range(2800, 3700)),
                       7'($urandom_range(0, 100)), 7'($urandom_range(0, 100)),
                       16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)));
            if (ph == 3) pressure_go = 1;
            level = $urandom_range(1200, 3200);
            for (int r = 0; r < 8; r++) begin
                if ($urandom_range(0, 4) == 0)
                    send_reading(2048, 2048, 1'($urandom));
                else
                    send_reading(level, 30, 1'($urandom));
                level += $urandom_range(0, 400) - 200;
                if (level < 0) level = 0;
                if (level > 4095) level = 4095;
            end
            drain();
        end

        drain();
        if (sb.fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/bvfg_pkg.sv
rtl/bvfg_front.sv
rtl/bvfg_queue.sv
rtl/bvfg_back.sv
rtl/battery_voltage_fuel_gauge.sv
tb/testbench.sv
